FILE: hdl/radix2_dif_fft_engine_assert.svh
// assertion macros for the radix-2 dif fft engine
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef RADIX2_DIF_FFT_ENGINE_ASSERT_SVH
`define RADIX2_DIF_FFT_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FFT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define FFT_ASSERT(lbl, clk, rstn, prop, msg)
`define FFT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: hdl/r2fft_pkg.sv
// shared types and constants for the radix-2 dif fft engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package r2fft_pkg;
  localparam int MaxPoints = 1024;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int TwAddrW = AddrW - 1;
  localparam int MaxLog = AddrW;
  localparam int StageW = $clog2(MaxLog + 1);

  localparam logic [1:0] FuncLoadSample = 2'd0;
  localparam logic [1:0] FuncLoadTw = 2'd1;
  localparam logic [1:0] FuncRun = 2'd2;
  localparam logic [1:0] FuncRead = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic              smp_wr;    // load a sample
    logic              tw_wr;     // load a twiddle
    logic              rd;        // read a bin
    logic              clr_ovf;   // start of run
    logic              bf_rd;     // read butterfly operands
    logic              last;      // last stage, no twiddle
    logic [AddrW-1:0]  addr_u;
    logic [AddrW-1:0]  addr_v;
    logic [TwAddrW-1:0] addr_t;
  } dp_cmd_t;

  function automatic logic [AddrW-1:0] bit_rev(logic [AddrW-1:0] x, logic [StageW-1:0] l);
    logic [AddrW-1:0] r;
    r = '0;
    for (int b = 0; b < AddrW; b++) begin
      if (b < int'(l)) r[int'(l) - 1 - b] = x[b];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: hdl/radix2_dif_fft_engine.sv
// Radix-2 DIF FFT engine. Items on s_axis: tuser = func (0 load sample, 1 load twiddle,
// 2 run, 3 read bin); tdata = {data_imag, data_real, index}. Loads and reads are taken
// one at a time; a read passes the sample memory read register and a hold register to
// its result. In a run, one butterfly unit shares the single sample memory write port
// and drains its three-stage pipeline before the next operand read. A run returns kind 1
// on m_axis; a read returns the bin at the bit-reversed index.
// depends on r2fft_pkg, r2fft_ctrl, r2fft_datapath
`timescale 1ns / 1ps
`default_nettype none
module radix2_dif_fft_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // index[9:0], data_real[25:10], data_imag[41:26]
  input  wire logic [1:0]  s_axis_tuser,   // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // bin_real[31:0], bin_imag[63:32]
  output logic [1:0]       m_axis_tuser,   // kind[0], saturated[1]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i
);
  logic [3:0] log2_q;
  r2fft_pkg::dp_cmd_t cmd;
  logic signed [31:0] rd_re, rd_im;
  logic ovf, kind;

  // size register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) log2_q <= 4'd10;
    else if (cfg_valid_i) log2_q <= cfg_data_i;
  end

  r2fft_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .func_i (s_axis_tuser), .index_i (s_axis_tdata[9:0]), .log2_i (log2_q),
    .cmd_o (cmd), .res_valid_o (m_axis_tvalid), .res_kind_o (kind),
    .res_ready_i (m_axis_tready)
  );

  r2fft_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd),
    .data_re_i (s_axis_tdata[25:10]), .data_im_i (s_axis_tdata[41:26]),
    .rd_re_o (rd_re), .rd_im_o (rd_im), .ovf_o (ovf)
  );

  // hold read data until the result transfer
  logic [63:0] bin_q;
  logic rd_d1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_d1_q <= 1'b0;
    else rd_d1_q <= cmd.rd;
  end
  always_ff @(posedge clk_i) begin
    if (rd_d1_q) bin_q <= {rd_im, rd_re};
  end
  assign m_axis_tdata = kind ? 64'd0 : bin_q;
  assign m_axis_tuser = {ovf, kind};
endmodule
`default_nettype wire

FILE: hdl/r2fft_datapath.sv
// sample and twiddle memories with the butterfly pipeline
// depends on r2fft_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "radix2_dif_fft_engine_assert.svh"
module r2fft_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire r2fft_pkg::dp_cmd_t cmd_i,
  input  wire logic signed [15:0] data_re_i,
  input  wire logic signed [15:0] data_im_i,
  output logic signed [31:0]     rd_re_o,
  output logic signed [31:0]     rd_im_o,
  output logic                   ovf_o
);
  localparam int AW = r2fft_pkg::AddrW;

  logic [63:0] smp_mem [r2fft_pkg::MaxPoints];
  logic [31:0] tw_mem [r2fft_pkg::MaxPoints/2];

  // pipeline stage 1: memory reads
  logic [63:0] a_q, b_q;
  logic [31:0] w_q;
  logic        s1_vld_q, s1_last_q;
  logic [AW-1:0] s1_u_q, s1_v_q;
  // stage 2: sum, difference, products
  logic signed [32:0] dr_q, di_q;
  logic signed [31:0] sr_q, si_q;
  logic signed [48:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic        s2_vld_q, s2_last_q, s2_ovf_q;
  logic [AW-1:0] s2_u_q, s2_v_q;
  // stage 3: writeback
  logic        s3_vld_q, s3_ovf_q;
  logic [AW-1:0] s3_u_q, s3_v_q;
  logic [63:0] s3_up_q, s3_lo_q;
  logic        s3_wr2_q;
  logic        ovf_q;

  function automatic logic signed [31:0] sat(logic signed [50:0] v, output logic o);
    o = 1'b0;
    if (v > 51'sd2147483647) begin o = 1'b1; return 32'sh7fffffff; end
    if (v < -51'sd2147483648) begin o = 1'b1; return 32'sh80000000; end
    return v[31:0];
  endfunction

  // memory reads and the twiddle write
  always_ff @(posedge clk_i) begin
    a_q <= smp_mem[cmd_i.rd ? cmd_i.addr_u : cmd_i.addr_u];
    b_q <= smp_mem[cmd_i.addr_v];
    w_q <= tw_mem[cmd_i.addr_t];
    if (cmd_i.tw_wr) tw_mem[cmd_i.addr_t] <= {data_im_i, data_re_i};
  end

  // sample memory write port, shared by loads and both butterfly writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_wr)
      smp_mem[cmd_i.addr_u] <= {{16{data_im_i[15]}}, data_im_i, {16{data_re_i[15]}}, data_re_i};
    else if (s3_vld_q)
      smp_mem[s3_u_q] <= s3_up_q;
    else if (s3_wr2_q)
      smp_mem[s3_v_q] <= s3_lo_q;
  end

  assign rd_re_o = a_q[31:0];
  assign rd_im_o = a_q[63:32];

  // arithmetic pipeline
  logic signed [31:0] ar, ai, br, bi;
  logic signed [15:0] wr, wi;
  logic signed [32:0] dr, di;
  logic signed [31:0] sr, si;
  logic o1, o2;
  always_comb begin
    ar = a_q[31:0]; ai = a_q[63:32];
    br = b_q[31:0]; bi = b_q[63:32];
    wr = w_q[15:0]; wi = w_q[31:16];
    dr = 33'(ar) - 33'(br);
    di = 33'(ai) - 33'(bi);
    sr = sat(51'(33'(ar) + 33'(br)), o1);
    si = sat(51'(33'(ai) + 33'(bi)), o2);
  end

  always_ff @(posedge clk_i) begin
    dr_q <= dr; di_q <= di; sr_q <= sr; si_q <= si;
    p_rr_q <= dr * wr; p_ii_q <= di * wi;
    p_ri_q <= dr * wi; p_ir_q <= di * wr;
    s1_u_q <= cmd_i.addr_u; s1_v_q <= cmd_i.addr_v;
    s2_u_q <= s1_u_q; s2_v_q <= s1_v_q;
    s2_last_q <= s1_last_q;
    s2_ovf_q <= o1 | o2;
  end

  logic signed [50:0] re_sum, im_sum;
  logic signed [31:0] lo_re, lo_im;
  logic o3, o4;
  always_comb begin
    re_sum = 51'(p_rr_q) - 51'(p_ii_q) + 51'sd16384;
    im_sum = 51'(p_ri_q) + 51'(p_ir_q) + 51'sd16384;
    if (s2_last_q) begin
      lo_re = sat(51'(dr_q), o3);
      lo_im = sat(51'(di_q), o4);
    end else begin
      lo_re = sat(re_sum >>> 15, o3);
      lo_im = sat(im_sum >>> 15, o4);
    end
  end

  always_ff @(posedge clk_i) begin
    s3_u_q <= s2_u_q; s3_v_q <= s2_v_q;
    s3_up_q <= {si_q, sr_q};
    s3_lo_q <= {lo_im, lo_re};
    s3_ovf_q <= s2_ovf_q | o3 | o4;
  end

  // control flags of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0; s1_last_q <= 1'b0; s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0; s3_wr2_q <= 1'b0; ovf_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.bf_rd;
      s1_last_q <= cmd_i.last;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s3_wr2_q <= s3_vld_q;
      if (cmd_i.clr_ovf) ovf_q <= 1'b0;
      else if (s3_vld_q && s3_ovf_q) ovf_q <= 1'b1;
    end
  end
  assign ovf_o = ovf_q;

  `FFT_ASSERT_NEVER(a_wr_clash, clk_i, rst_ni, cmd_i.smp_wr && (s3_vld_q || s3_wr2_q), "load during butterfly writeback")
  `FFT_ASSERT(a_wr2_follows, clk_i, rst_ni, s3_vld_q |=> s3_wr2_q, "second write missing")
  `FFT_ASSERT_NEVER(a_clr_busy, clk_i, rst_ni, cmd_i.clr_ovf && s3_vld_q, "flag cleared during run")
endmodule
`default_nettype wire

FILE: hdl/r2fft_ctrl.sv
// controller: decodes items and sequences butterflies stage by stage
// depends on r2fft_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "radix2_dif_fft_engine_assert.svh"
module r2fft_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [9:0]  index_i,
  input  wire logic [3:0]  log2_i,
  output r2fft_pkg::dp_cmd_t cmd_o,
  output logic             res_valid_o,
  output logic             res_kind_o,
  input  wire logic        res_ready_i
);
  localparam int AW = r2fft_pkg::AddrW;
  localparam int SW = r2fft_pkg::StageW;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StBfly = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StRead = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [SW-1:0] stage_q, stage_d, l_used;
  logic [AW-1:0] cnt_q, cnt_d;     // butterfly number within stage
  logic [2:0] wait_q, wait_d;
  logic kind_q, kind_d;
  logic accept;

  // clamp the configured size
  always_comb begin
    if (log2_i < 4'd2) l_used = SW'(2);
    else if (log2_i > 4'(r2fft_pkg::MaxLog)) l_used = SW'(r2fft_pkg::MaxLog);
    else l_used = log2_i[SW-1:0];
  end

  assign in_ready_o = (state_q == StIdle);
  assign accept = in_valid_i && in_ready_o;

  // butterfly addresses: half = n >> (s+1), k = cnt mod half
  logic [AW:0] half, hmask;
  logic [AW-1:0] k, u;
  always_comb begin
    half = (AW+1)'(1) << (l_used - stage_q - SW'(1));
    hmask = half - 1'b1;
    k = cnt_q & hmask[AW-1:0];
    u = ((cnt_q & ~hmask[AW-1:0]) << 1) | k;
  end

  always_comb begin
    state_d = state_q; stage_d = stage_q; cnt_d = cnt_q; wait_d = wait_q;
    kind_d = kind_q;
    cmd_o = '0;
    cmd_o.addr_u = index_i;
    cmd_o.addr_t = index_i[AW-2:0];
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (func_i)
            r2fft_pkg::FuncLoadSample: cmd_o.smp_wr = 1'b1;
            r2fft_pkg::FuncLoadTw: cmd_o.tw_wr = (index_i[AW-1] == 1'b0);
            r2fft_pkg::FuncRun: begin
              cmd_o.clr_ovf = 1'b1;
              state_d = StBfly; stage_d = '0; cnt_d = '0;
              kind_d = 1'b1;
            end
            r2fft_pkg::FuncRead: begin
              cmd_o.rd = 1'b1;
              cmd_o.addr_u = r2fft_pkg::bit_rev(index_i & AW'(((AW+1)'(1) << l_used) - 1'b1), l_used);
              state_d = StRead; kind_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      StBfly: begin
        // one butterfly at a time: the full pipeline drains before the next read
        cmd_o.addr_u = u;
        cmd_o.addr_v = u | half[AW-1:0];
        cmd_o.addr_t = (AW-1)'(k << stage_q);
        cmd_o.last = (stage_q == l_used - SW'(1));
        cmd_o.bf_rd = (wait_q == 3'd0);
        wait_d = wait_q + 3'd1;
        if (wait_q == 3'd4) begin
          wait_d = '0;
          if (cnt_q == AW'(((AW+1)'(1) << (l_used - SW'(1))) - 1'b1)) begin
            cnt_d = '0;
            if (stage_q == l_used - SW'(1)) state_d = StOut;
            else stage_d = stage_q + SW'(1);
          end else cnt_d = cnt_q + 1'b1;
        end
      end
      StRead: state_d = StOut;
      StOut: if (res_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign res_valid_o = (state_q == StOut);
  assign res_kind_o = kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; stage_q <= '0; cnt_q <= '0; wait_q <= '0;
      kind_q <= 1'b0;
    end else begin
      state_q <= state_d; stage_q <= stage_d; cnt_q <= cnt_d; wait_q <= wait_d;
      kind_q <= kind_d;
    end
  end

  `FFT_ASSERT(a_run_starts, clk_i, rst_ni, (accept && func_i == r2fft_pkg::FuncRun) |=> (state_q == StBfly), "run did not start")
  `FFT_ASSERT(a_read_out, clk_i, rst_ni, (state_q == StRead) |=> res_valid_o, "read result missing")
  `FFT_ASSERT_NEVER(a_stage_range, clk_i, rst_ni, (state_q == StBfly) && (stage_q >= l_used), "stage beyond size")
endmodule
`default_nettype wire

FILE: verif/radix2_dif_fft_engine_tb.sv
// self-checking testbench for the radix-2 dif fft engine: loads, runs and bin reads
// are predicted in a scoreboard class and compared with every result transfer
// depends on r2fft_pkg and radix2_dif_fft_engine
`timescale 1ns / 1ps

class fft_scoreboard;
  typedef struct {
    logic               kind;
    logic signed [31:0] bin_re;
    logic signed [31:0] bin_im;
    logic               sat;
  } bin_result_t;

  logic signed [31:0] smp_re[r2fft_pkg::MaxPoints];
  logic signed [31:0] smp_im[r2fft_pkg::MaxPoints];
  logic signed [15:0] tw_re[r2fft_pkg::MaxPoints/2];
  logic signed [15:0] tw_im[r2fft_pkg::MaxPoints/2];
  logic               ovf;
  logic [3:0]         log2_pts;
  bin_result_t        pending_bins[$];
  int                 errors;

  function new();
    ovf      = 1'b0;
    log2_pts = 4'd10;
    errors   = 0;
  endfunction

  function int stages();
    int l;
    l = log2_pts;
    if (l < 2) l = 2;
    if (l > r2fft_pkg::MaxLog) l = r2fft_pkg::MaxLog;
    return l;
  endfunction

  function logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // in-place dif transform over the first 2^L entries
  function void transform();
    int     l, n, half, u, v, t;
    longint ar, ai, br, bi, dr, di, wr, wi;
    l   = stages();
    n   = 1 << l;
    ovf = 1'b0;
    for (int s = 0; s < l; s++) begin
      half = n >> (s + 1);
      for (int g = 0; g < n; g += 2 * half) begin
        for (int k = 0; k < half; k++) begin
          u  = g + k;
          v  = u + half;
          ar = smp_re[u];
          ai = smp_im[u];
          br = smp_re[v];
          bi = smp_im[v];
          dr = ar - br;
          di = ai - bi;
          smp_re[u] = clip32(ar + br);
          smp_im[u] = clip32(ai + bi);
          if (half == 1) begin
            smp_re[v] = clip32(dr);
            smp_im[v] = clip32(di);
          end else begin
            t  = (k << s) & (r2fft_pkg::MaxPoints/2 - 1);
            wr = tw_re[t];
            wi = tw_im[t];
            smp_re[v] = clip32((dr * wr - di * wi + 16384) >>> 15);
            smp_im[v] = clip32((dr * wi + di * wr + 16384) >>> 15);
          end
        end
      end
    end
  endfunction

  // accepted input transfer: update state and queue the expected result
  function void note_item(logic [1:0] func, logic [9:0] idx,
                          logic signed [15:0] re, logic signed [15:0] im);
    bin_result_t r;
    int          l, a;
    case (func)
      r2fft_pkg::FuncLoadSample: begin
        smp_re[idx] = 32'(re);
        smp_im[idx] = 32'(im);
      end
      r2fft_pkg::FuncLoadTw: begin
        if (idx < r2fft_pkg::MaxPoints/2) begin
          tw_re[idx] = re;
          tw_im[idx] = im;
        end
      end
      r2fft_pkg::FuncRun: begin
        transform();
        r.kind   = 1'b1;
        r.bin_re = '0;
        r.bin_im = '0;
        r.sat    = ovf;
        pending_bins.push_back(r);
      end
      default: begin
        l = stages();
        a = 0;
        for (int b = 0; b < l; b++) a = (a << 1) | ((idx >> b) & 1);
        r.kind   = 1'b0;
        r.bin_re = smp_re[a];
        r.bin_im = smp_im[a];
        r.sat    = ovf;
        pending_bins.push_back(r);
      end
    endcase
  endfunction

  // accepted output transfer against the oldest expectation
  function void check_result(logic kind, logic signed [31:0] re,
                             logic signed [31:0] im, logic sat);
    bin_result_t r;
    if (pending_bins.size() == 0) begin
      $error("unexpected result transfer kind %0d", kind);
      errors++;
      return;
    end
    r = pending_bins.pop_front();
    if (kind !== r.kind) begin
      $error("kind: expected %0d actual %0d", r.kind, kind);
      errors++;
    end
    if (re !== r.bin_re) begin
      $error("bin_real: expected %0d actual %0d", r.bin_re, re);
      errors++;
    end
    if (im !== r.bin_im) begin
      $error("bin_imag: expected %0d actual %0d", r.bin_im, im);
      errors++;
    end
    if (sat !== r.sat) begin
      $error("saturated: expected %0d actual %0d", r.sat, sat);
      errors++;
    end
  endfunction
endclass

module radix2_dif_fft_engine_tb;

  localparam int WatchdogLimit = 200000;
  localparam int DrainCycles   = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;

  fft_scoreboard sb = new();
  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  int  hold_cycles = 0;
  int  quiet_cycles = 0;
  int  items_sent = 0;
  bit  smp_written[r2fft_pkg::MaxPoints];
  bit  tw_written[r2fft_pkg::MaxPoints/2];
  int  cur_log = 10;

  radix2_dif_fft_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // monitor: results first, they always belong to earlier inputs
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[63:32],
                      m_axis_tuser[1]);
    if (s_axis_tvalid && s_axis_tready)
      sb.note_item(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[25:10],
                   s_axis_tdata[41:26]);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function int used_log();
    return (cur_log < 2) ? 2 : (cur_log > r2fft_pkg::MaxLog) ? r2fft_pkg::MaxLog : cur_log;
  endfunction

  function bit bins_ready();
    int n;
    n = 1 << used_log();
    for (int i = 0; i < n; i++) if (!smp_written[i]) return 1'b0;
    for (int i = 0; i < n / 2; i++) if (!tw_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  // a read is legal when the sample at its bit-reversed address is loaded
  function bit read_ok(int idx);
    int l, a;
    l = used_log();
    a = 0;
    for (int b = 0; b < l; b++) a = (a << 1) | ((idx >> b) & 1);
    return smp_written[a];
  endfunction

  // one input transfer with a random idle gap before it
  task automatic send_item(logic [1:0] func, int idx, int re, int im);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'd0, 16'(im), 16'(re), 10'(idx)};
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == r2fft_pkg::FuncLoadSample) smp_written[idx] = 1'b1;
    if (func == r2fft_pkg::FuncLoadTw && idx < r2fft_pkg::MaxPoints / 2)
      tw_written[idx] = 1'b1;
    items_sent++;
  endtask

  // wait for every expected result, let the block settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_bins.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_size(logic [3:0] l);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= l;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.log2_pts = l;
    cur_log     = l;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // fill the samples and twiddles that the current size needs
  task automatic load_set(bit extreme);
    int n;
    n = 1 << used_log();
    for (int i = 0; i < n; i++) begin
      if (extreme)
        send_item(r2fft_pkg::FuncLoadSample, i, (i % 2) ? 16'h8000 : 16'h7fff,
                  (i % 4 < 2) ? 16'h7fff : 16'h8000);
      else
        send_item(r2fft_pkg::FuncLoadSample, i, $urandom, $urandom);
      if ($urandom_range(9) == 0)
        send_item(r2fft_pkg::FuncLoadTw, $urandom_range(1023, 512), $urandom, $urandom);
    end
    for (int i = 0; i < n / 2; i++)
      send_item(r2fft_pkg::FuncLoadTw, i, extreme ? 16'h8000 : $urandom,
                extreme ? 16'h8000 : $urandom);
  endtask

  // random mix: runs once the set is loaded, reads of loaded bins only
  task automatic random_ops(int count);
    int pick, idx;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      idx  = $urandom_range(1023);
      if (pick < 15)
        send_item(r2fft_pkg::FuncLoadSample, idx, $urandom, $urandom);
      else if (pick < 27)
        send_item(r2fft_pkg::FuncLoadTw, idx, $urandom, $urandom);
      else if (pick < 40 && bins_ready())
        send_item(r2fft_pkg::FuncRun, idx, $urandom, $urandom);
      else if (pick >= 40 && read_ok(idx))
        send_item(r2fft_pkg::FuncRead, idx, $urandom, $urandom);
      else
        send_item(r2fft_pkg::FuncLoadSample, $urandom_range(1023), $urandom, $urandom);
    end
  endtask

  task automatic idle_mode(int p);
    case (p % 4)
      0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      1: begin src_idle_pct = 51; snk_idle_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_idle_pct = 51; end
      default: begin src_idle_pct = 32; snk_idle_pct = 32; end
    endcase
  endtask

  initial begin
    int sizes[$];
    int p;
    sizes = '{3, 4, 8, 15, 2, 11, 5, 0, 1, 4, 3, 5, 2};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: smallest size, extreme values, reads before and after a run
    set_size(4'd2);
    send_item(r2fft_pkg::FuncLoadSample, 0, 16'h7fff, 16'h8000);
    send_item(r2fft_pkg::FuncLoadSample, 1, 16'h8000, 16'h7fff);
    send_item(r2fft_pkg::FuncLoadSample, 2, 16'h7fff, 16'h7fff);
    send_item(r2fft_pkg::FuncLoadSample, 3, 16'h8000, 16'h8000);
    send_item(r2fft_pkg::FuncLoadTw, 0, 16'h7fff, 16'h0000);
    send_item(r2fft_pkg::FuncLoadTw, 1, 16'h8000, 16'h8000);
    send_item(r2fft_pkg::FuncLoadTw, 1023, 16'hffff, 16'hffff);
    send_item(r2fft_pkg::FuncRead, 0, 16'h0, 16'h0);
    send_item(r2fft_pkg::FuncRead, 1, 16'h0, 16'h0);
    send_item(r2fft_pkg::FuncRead, 1023, 16'h0, 16'h0);
    send_item(r2fft_pkg::FuncRun, 0, 16'h0, 16'h0);
    for (int i = 0; i < 4; i++) send_item(r2fft_pkg::FuncRead, i, 16'h0, 16'h0);
    send_item(r2fft_pkg::FuncRead, 1022, 16'hffff, 16'hffff);
    send_item(r2fft_pkg::FuncRun, 1023, 16'hffff, 16'hffff);
    send_item(r2fft_pkg::FuncRead, 3, 16'h0, 16'h0);

    // random phases over several sizes and idle patterns
    p = 0;
    while (p < sizes.size() || items_sent < 850) begin
      set_size(4'(p < sizes.size() ? sizes[p] : $urandom_range(5, 2)));
      idle_mode(p);
      if (!bins_ready() && used_log() <= 8)
        load_set(p < sizes.size() && sizes[p] == 8);
      if (p == 2) send_item(r2fft_pkg::FuncRun, 0, 16'h0, 16'h0);
      if (p == 1) begin
        // long receiver hold-off while reads keep coming
        hold_cycles = 300;
        for (int i = 0; i < 40; i++)
          send_item(r2fft_pkg::FuncRead, $urandom_range(1023), 0, 0);
      end
      random_ops(p == 2 ? 8 : 30);
      p++;
    end

    drain();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
